// ===== rtl/hid_report_descriptor_parser_unit_macros.svh =====
// Assertion helpers for the HID descriptor parser.
`ifndef HID_REPORT_DESCRIPTOR_PARSER_UNIT_MACROS_SVH
`define HID_REPORT_DESCRIPTOR_PARSER_UNIT_MACROS_SVH

// Check that a condition implies a consequence on the same edge.
`define HRD_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define HRD_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/hrd_pkg.sv =====
// ----------------------------------------------------------------------------
// hrd_pkg
// Shared types and constants of the HID report descriptor parser.
// ----------------------------------------------------------------------------
`default_nettype none
package hrd_pkg;
   localparam int ReportIds       = 256;
   localparam int UsageDepth      = 64;
   localparam int FieldsPerReport = 16;
   localparam int NestDepth       = 16;
   localparam int RidW  = $clog2(ReportIds);
   localparam int UlW   = $clog2(UsageDepth);
   localparam int NestW = $clog2(NestDepth);
   localparam int FprW  = $clog2(FieldsPerReport + 1);
   localparam int FrTab = 2 * ReportIds;
   localparam int FrW   = $clog2(FrTab);

   typedef enum logic [4:0] {
      ST_FIELD = 5'd0, ST_NO_ID = 5'd1, ST_ID_HIGH = 5'd2, ST_FIELDS_FULL = 5'd3,
      ST_COLL_USAGES = 5'd4, ST_NOT_APP = 5'd5, ST_NESTING = 5'd6,
      ST_UNMATCHED = 5'd7, ST_MAIN_TAG = 5'd8, ST_SIZE = 5'd9, ST_PUSH_POP = 5'd10,
      ST_GLOBAL_TAG = 5'd11, ST_USAGES_FULL = 5'd12, ST_ZERO_USAGE = 5'd13,
      ST_USAGE_RANGE = 5'd14, ST_DELIMITER = 5'd15, ST_LOCAL_TAG = 5'd16,
      ST_LONG_ITEM = 5'd17, ST_OVERFLOW = 5'd18
   } status_type;

   typedef struct packed {
      logic [1:0]  item_type;
      logic [3:0]  tag;
      logic [2:0]  size;
      logic [31:0] value;
      logic        overflow;
      logic        last_byte;
   } item_type_s_type;

   typedef struct packed {
      logic [4:0]  status;
      logic        is_feature;
      logic [7:0]  report_number;
      logic [3:0]  field_slot;
      logic [31:0] root_usage;
      logic [31:0] usage_code;
      logic [31:0] logical_low;
      logic [31:0] logical_high;
      logic [5:0]  bits_per_control;
      logic [31:0] control_count;
      logic [1:0]  field_flags;
      logic        last_of_run;
   } result_type;

   localparam logic [3:0] MainInput = 4'h8, MainOutput = 4'h9, MainFeature = 4'hb,
      MainColl = 4'ha, MainEndColl = 4'hc;
   localparam logic [1:0] TypeMain = 2'd0, TypeGlobal = 2'd1, TypeLocal = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/hid_report_descriptor_parser_unit.sv =====
// Parses a USB HID report descriptor one byte per word; each Input or Feature
// item yields a run of field words (one per usage), and any error yields one
// error word and silences the parser until the word marked tlast. A byte is
// taken per cycle while the item queue has room; each field word passes
// through the back end's S_FILL and S_EMIT states. After reset and after every
// tlast word the back end clears its 512-entry field-count memory.
`default_nettype none
module hid_report_descriptor_parser_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // data_byte
   input  wire          req_tlast,   // end_of_descriptor
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [191:0] rsp_tdata,   // status, is_feature, report_number, field_slot,
                                     // root usage, usage_code, logical_low,
                                     // logical_high, bits_per_control, control_count,
                                     // field_flags, zero fill
   output logic         rsp_tlast    // last_of_run
);
   import hrd_pkg::*;
   logic iv, ir, fl;
   item_type_s_type id;
   result_type rw;

   hrd_front u_front (.clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .flush(fl), .item_valid(iv), .item_ready(ir), .item_data(id));
   hrd_back u_back (.clock, .reset, .item_valid(iv), .item_ready(ir), .item_data(id),
      .err_flush(fl), .rsp_tvalid, .rsp_tready, .rsp_word(rw));

   assign rsp_tdata = {6'd0, rw.field_flags, rw.control_count, rw.bits_per_control,
      rw.logical_high, rw.logical_low, rw.usage_code, rw.root_usage,
      rw.field_slot, rw.report_number, rw.is_feature, rw.status};
   assign rsp_tlast = rw.last_of_run;
endmodule
`default_nettype wire

// ===== rtl/hrd_front.sv =====
// ----------------------------------------------------------------------------
// hrd_front
// Assembles short items from descriptor bytes and queues them.
// ----------------------------------------------------------------------------
`default_nettype none
module hrd_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire  [7:0]               req_tdata,
   input  wire                      req_tlast,
   input  wire                      flush,
   output logic                     item_valid,
   input  wire                      item_ready,
   output hrd_pkg::item_type_s_type item_data
);
   import hrd_pkg::*;
   logic [7:0]  prefix_ff, prefix_in;
   logic [2:0]  pending_ff, pending_in;
   logic [31:0] acc_ff, acc_in;
   logic        skip_ff, skip_in;
   // two-entry queue
   item_type_s_type q_ff [2];
   logic [1:0]  cnt_ff;
   logic        rd_ff, wr_ff;
   logic        push;
   item_type_s_type pkt;
   logic [2:0]  sz;
   logic [1:0]  pos;

   assign req_tready = (cnt_ff != 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item_data  = q_ff[rd_ff];

   always_comb begin
      prefix_in = prefix_ff; pending_in = pending_ff; acc_in = acc_ff;
      skip_in = skip_ff; push = 1'b0; pkt = '0;
      sz = (prefix_ff[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix_ff[1:0]};
      pos = 2'(sz - pending_ff);
      if (req_tvalid && req_tready) begin
         if (!skip_ff) begin
            if (pending_ff == 3'd0) begin
               prefix_in = req_tdata;
               acc_in = '0;
               pending_in = (req_tdata[1:0] == 2'd3) ? 3'd4 : {1'b0, req_tdata[1:0]};
            end else begin
               acc_in = acc_ff | (32'(req_tdata) << {pos, 3'b000});
               pending_in = pending_ff - 3'd1;
            end
         end
         pkt.item_type = prefix_in[3:2];
         pkt.tag = prefix_in[7:4];
         pkt.size = (prefix_in[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix_in[1:0]};
         pkt.value = acc_in;
         pkt.last_byte = req_tlast;
         pkt.overflow = (pending_in != 3'd0);
         push = !skip_ff && (pending_in == 3'd0 || req_tlast);
         if (req_tlast) begin
            prefix_in = '0; pending_in = '0; acc_in = '0; skip_in = 1'b0;
         end else if (push && pkt.item_type == 2'd3) begin
            skip_in = 1'b1;  // long item errors out; drop until end
         end
         if (skip_ff && req_tlast) begin
            push = 1'b1; pkt.item_type = TypeGlobal; pkt.tag = 4'h3; pkt.overflow = 1'b0;
         end
      end
      if (flush && !req_tlast) skip_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0; pending_ff <= '0; acc_ff <= '0; skip_ff <= 1'b0;
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         prefix_ff <= prefix_in; pending_ff <= pending_in; acc_ff <= acc_in;
         skip_ff <= skip_in;
         if (push) begin
            q_ff[wr_ff] <= pkt;
            wr_ff <= ~wr_ff;
         end
         if (item_valid && item_ready) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(item_valid && item_ready);
      end
   end
endmodule
`default_nettype wire

// ===== rtl/hrd_back.sv =====
// ----------------------------------------------------------------------------
// hrd_back
// Executes items against the tables and emits field and error words.
// ----------------------------------------------------------------------------
`default_nettype none
module hrd_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      item_valid,
   output logic                     item_ready,
   input  hrd_pkg::item_type_s_type item_data,
   output logic                     err_flush,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output hrd_pkg::result_type      rsp_word
);
   import hrd_pkg::*;
   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOOK, S_FILL, S_EMIT, S_WAIT} state_type;
   state_type   state_ff;
   logic [15:0] page_ff;
   logic [31:0] lmin_ff, lmax_ff, rid_ff, rcnt_ff;
   logic [5:0]  rsize_ff;
   logic [UlW:0] ulen_ff;
   logic [31:0] ulist [UsageDepth];
   logic [31:0] app_ff;
   logic [31:0] last_ff, rd_ff;
   logic [NestW:0] depth_ff;
   logic [FprW-1:0] fpr [FrTab];
   logic [FprW-1:0] fpr_rd_ff;
   logic [FrW-1:0]  clr_ff, fidx_ff;
   logic        err_ff;
   item_type_s_type it_ff;
   logic [UlW:0] k_ff, n_ff;
   logic [31:0] ext_u, sval;
   logic [UlW:0] target;
   logic        to_look;

   assign item_ready = (state_ff == S_IDLE) && !rsp_tvalid;
   assign err_flush = 1'b0;

   always_comb begin
      sval = item_data.value;
      if (item_data.size == 3'd1) sval = {{24{item_data.value[7]}}, item_data.value[7:0]};
      if (item_data.size == 3'd2) sval = {{16{item_data.value[15]}}, item_data.value[15:0]};
      ext_u = (item_data.value < 32'h10000) ? {page_ff, item_data.value[15:0]} : item_data.value;
      target = (rcnt_ff > 32'(UsageDepth)) ? (UlW+1)'(UsageDepth) : rcnt_ff[UlW:0];
      // Input/Feature item that goes on to the field-count lookup
      to_look = (item_data.item_type == TypeMain) &&
                (item_data.tag == MainInput || item_data.tag == MainFeature) &&
                (rid_ff != 32'd0) && (rid_ff < 32'(ReportIds));
   end

   task automatic fail(input status_type code);
      rsp_word <= '{status: code, last_of_run: 1'b1, default: '0};
      rsp_tvalid <= 1'b1;
      err_ff <= 1'b1;
   endtask

   task automatic clear_regs();
      page_ff <= '0; lmin_ff <= '0; lmax_ff <= '0; rid_ff <= '0; rcnt_ff <= '0;
      rsize_ff <= '0; ulen_ff <= '0; app_ff <= '0; depth_ff <= '0; err_ff <= 1'b0;
   endtask

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; rsp_tvalid <= 1'b0; clear_regs();
      end else begin
         // S_EMIT reloads the output register itself when the word leaves
         if (rsp_tvalid && rsp_tready && state_ff != S_EMIT) rsp_tvalid <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               fpr[clr_ff] <= '0;
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == FrW'(FrTab - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (item_valid && item_ready) begin
               it_ff <= item_data;
               if (item_data.last_byte) begin
                  clr_ff <= '0;
               end
               if (err_ff) begin
                  if (item_data.last_byte) begin clear_regs(); state_ff <= S_CLEAR; end
               end else if (item_data.overflow) begin
                  fail(ST_OVERFLOW);
                  state_ff <= S_WAIT;
               end else begin
                  case (item_data.item_type)
                     TypeMain: case (item_data.tag)
                        MainInput, MainFeature: begin
                           if (rid_ff == 32'd0) fail(ST_NO_ID);
                           else if (rid_ff >= 32'(ReportIds)) fail(ST_ID_HIGH);
                           else begin
                              fidx_ff <= {item_data.tag == MainFeature, rid_ff[RidW-1:0]};
                              fpr_rd_ff <= fpr[{item_data.tag == MainFeature,
                                                rid_ff[RidW-1:0]}];
                              if (ulen_ff != 0) last_ff <= ulist[UlW'(ulen_ff - 1'b1)];
                              state_ff <= S_LOOK;
                           end
                        end
                        MainOutput: ulen_ff <= '0;
                        MainColl: begin
                           if (ulen_ff > 1) fail(ST_COLL_USAGES);
                           else if (depth_ff == 0 && item_data.value != 32'd1) fail(ST_NOT_APP);
                           else if (depth_ff >= (NestW+1)'(NestDepth)) fail(ST_NESTING);
                           else begin
                              if (depth_ff == 0) app_ff <= (ulen_ff != 0) ? ulist[0] : 32'd0;
                              depth_ff <= depth_ff + 1'b1; ulen_ff <= '0;
                           end
                        end
                        MainEndColl: begin
                           if (depth_ff == 0) fail(ST_UNMATCHED);
                           else begin depth_ff <= depth_ff - 1'b1; ulen_ff <= '0; end
                        end
                        default: fail(ST_MAIN_TAG);
                     endcase
                     TypeGlobal: case (item_data.tag)
                        4'h0: page_ff <= item_data.value[15:0];
                        4'h1: lmin_ff <= sval;
                        4'h2: lmax_ff <= sval;
                        4'h3, 4'h4, 4'h5, 4'h6: ;
                        4'h7: if (item_data.value > 32'd32) fail(ST_SIZE);
                              else rsize_ff <= item_data.value[5:0];
                        4'h8: rid_ff <= item_data.value;
                        4'h9: rcnt_ff <= item_data.value;
                        4'ha, 4'hb: fail(ST_PUSH_POP);
                        default: fail(ST_GLOBAL_TAG);
                     endcase
                     TypeLocal: case (item_data.tag)
                        4'h0: begin
                           if (ulen_ff >= (UlW+1)'(UsageDepth)) fail(ST_USAGES_FULL);
                           else if (item_data.value == 32'd0) fail(ST_ZERO_USAGE);
                           else begin
                              ulist[UlW'(ulen_ff)] <= ext_u; ulen_ff <= ulen_ff + 1'b1;
                           end
                        end
                        4'h2: fail(ST_USAGE_RANGE);
                        4'ha: fail(ST_DELIMITER);
                        4'h1, 4'h3, 4'h4, 4'h5, 4'h7, 4'h8, 4'h9: ;
                        default: fail(ST_LOCAL_TAG);
                     endcase
                     default: fail(ST_LONG_ITEM);
                  endcase
                  // a field run ends the descriptor from S_LOOK or S_EMIT instead
                  if (item_data.last_byte && !to_look) state_ff <= S_WAIT;
               end
            end
            S_LOOK: begin
               if (fpr_rd_ff >= FprW'(FieldsPerReport)) begin
                  fail(ST_FIELDS_FULL);
                  state_ff <= it_ff.last_byte ? S_WAIT : S_IDLE;
               end else begin
                  fpr[fidx_ff] <= fpr_rd_ff + 1'b1;
                  n_ff <= (ulen_ff == 0) ? (UlW+1)'(1) :
                          ((target > ulen_ff) ? target : ulen_ff);
                  k_ff <= '0;
                  state_ff <= S_FILL;
               end
            end
            S_FILL: begin
               rd_ff <= (ulen_ff == 0) ? 32'd0 :
                        ((k_ff < ulen_ff) ? ulist[UlW'(k_ff)] : last_ff);
               state_ff <= S_EMIT;
            end
            S_EMIT: if (!rsp_tvalid || rsp_tready) begin
               rsp_tvalid <= 1'b1;
               rsp_word <= '{status: ST_FIELD,
                             is_feature: (it_ff.tag == MainFeature),
                             report_number: rid_ff[7:0],
                             field_slot: 4'(fpr_rd_ff),
                             root_usage: app_ff,
                             usage_code: rd_ff,
                             logical_low: lmin_ff,
                             logical_high: lmax_ff,
                             bits_per_control: rsize_ff,
                             control_count: rcnt_ff,
                             field_flags: {it_ff.value[2], it_ff.value[1]},
                             last_of_run: (k_ff + 1'b1 == n_ff)};
               if (k_ff + 1'b1 == n_ff) begin
                  ulen_ff <= '0;
                  state_ff <= it_ff.last_byte ? S_WAIT : S_IDLE;
               end else begin
                  k_ff <= k_ff + 1'b1; state_ff <= S_FILL;
               end
            end
            S_WAIT: if (!rsp_tvalid || rsp_tready) begin
               clear_regs(); clr_ff <= '0; state_ff <= S_CLEAR;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/hrd_checker.sv =====
// ----------------------------------------------------------------------------
// hrd_checker
// Port-level checks of the parser.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hid_report_descriptor_parser_unit_macros.svh"
module hrd_checker (
   input wire         clock,
   input wire         reset,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [191:0] rsp_tdata,
   input wire         rsp_tlast
);
   `HRD_ASSERT_IMP(a_err_last, clock, reset, rsp_tvalid && rsp_tdata[4:0] != 5'd0, rsp_tlast, "error word without tlast")
   `HRD_ASSERT_IMP(a_code, clock, reset, rsp_tvalid, rsp_tdata[4:0] <= 5'd18, "bad status")
   `HRD_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "word dropped")
endmodule
bind hid_report_descriptor_parser_unit hrd_checker u_chk (.clock, .reset, .rsp_tvalid,
   .rsp_tready, .rsp_tdata, .rsp_tlast);
`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HID report descriptor parser: streams
// descriptor bytes with bursty backpressure and compares every output word
// with a local model of the parser state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import hrd_pkg::*;

   // global and local item tags used by the bench
   localparam logic [3:0] GlUsagePage = 4'h0, GlLogMin = 4'h1, GlLogMax = 4'h2,
      GlPhysMin = 4'h3, GlRepSize = 4'h7, GlRepId = 4'h8, GlRepCount = 4'h9,
      GlPush = 4'ha, GlReserved = 4'hc;
   localparam logic [3:0] LcUsage = 4'h0, LcUsageMin = 4'h1, LcUsageMax = 4'h2,
      LcDesig = 4'h3, LcDelim = 4'ha, LcReserved = 4'hb;
   localparam logic [1:0] TypeLong = 2'd3;
   localparam logic [3:0] MainBadTag = 4'h0;
   localparam logic [31:0] CollApplication = 32'd1;
   localparam int IdleLimit = 4000;
   localparam int HoldOff   = 400;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } desc_byte_type;

   logic         clock, reset;
   logic         req_tvalid, req_tready, req_tlast;
   logic [7:0]   req_tdata;
   logic         rsp_tvalid, rsp_tready, rsp_tlast;
   logic [191:0] rsp_tdata;

   hid_report_descriptor_parser_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   desc_byte_type byte_queue[$];   // bytes waiting to be offered
   logic [7:0]  build_bytes[$];  // descriptor under construction
   result_type  expected_words[$];
   int          mismatches = 0;

   // ---------------------------------------------------------------------
   // parser model state
   // ---------------------------------------------------------------------
   logic [7:0]  m_prefix;
   int          m_pending;
   logic [31:0] m_value;
   logic [15:0] m_page;
   logic [31:0] m_lmin, m_lmax;
   logic [5:0]  m_rsize;
   logic [31:0] m_rid, m_rcount;
   logic [31:0] m_usages[UsageDepth];
   int          m_nusage;
   logic [31:0] m_colls[NestDepth];
   int          m_depth;
   int          m_fields[FrTab];
   bit          m_stuck;

   function automatic int size_of(logic [7:0] p);
      return (p[1:0] == 2'd3) ? 4 : int'(p[1:0]);
   endfunction

   function automatic void model_clear();
      m_prefix = '0; m_pending = 0; m_value = '0; m_page = '0;
      m_lmin = '0; m_lmax = '0; m_rsize = '0; m_rid = '0; m_rcount = '0;
      m_nusage = 0; m_depth = 0; m_stuck = 0;
      foreach (m_usages[i]) m_usages[i] = '0;
      foreach (m_colls[i]) m_colls[i] = '0;
      foreach (m_fields[i]) m_fields[i] = 0;
   endfunction

   function automatic void raise_error(status_type code);
      result_type r;
      r = '0;
      r.status = code;
      r.last_of_run = 1'b1;
      expected_words.push_back(r);
      m_stuck = 1;
   endfunction

   // Input/Feature item: one word per usage, last usage padded to the count
   function automatic void emit_fields(logic [31:0] flags, bit feat);
      result_type r;
      int idx, slot, n;
      logic [31:0] last_usage;
      if (m_rid == 0) begin
         raise_error(ST_NO_ID);
         return;
      end
      if (m_rid >= ReportIds) begin
         raise_error(ST_ID_HIGH);
         return;
      end
      idx = int'(feat) * ReportIds + int'(m_rid);
      if (m_fields[idx] >= FieldsPerReport) begin
         raise_error(ST_FIELDS_FULL);
         return;
      end
      slot = m_fields[idx];
      m_fields[idx]++;
      if (m_nusage > 0) begin
         last_usage = m_usages[m_nusage-1];
         while (m_nusage < m_rcount && m_nusage < UsageDepth) begin
            m_usages[m_nusage] = last_usage;
            m_nusage++;
         end
      end
      n = (m_nusage > 0) ? m_nusage : 1;
      for (int k = 0; k < n; k++) begin
         r = '0;
         r.status = ST_FIELD;
         r.is_feature = feat;
         r.report_number = m_rid[7:0];
         r.field_slot = slot[3:0];
         r.root_usage = m_colls[0];
         r.usage_code = (m_nusage > 0) ? m_usages[k] : '0;
         r.logical_low = m_lmin;
         r.logical_high = m_lmax;
         r.bits_per_control = m_rsize;
         r.control_count = m_rcount;
         r.field_flags = {flags[2], flags[1]};
         r.last_of_run = (k == n - 1);
         expected_words.push_back(r);
      end
      m_nusage = 0;
   endfunction

   function automatic void finish_item();
      logic [1:0]  ity;
      logic [3:0]  itag;
      int          sz;
      logic [31:0] u, s;
      ity = m_prefix[3:2];
      itag = m_prefix[7:4];
      sz = size_of(m_prefix);
      u = m_value;
      s = u;
      if (sz == 1 && u[7]) s = u | 32'hffffff00;
      else if (sz == 2 && u[15]) s = u | 32'hffff0000;
      case (ity)
         TypeMain: begin
            case (itag)
               MainInput:   emit_fields(u, 1'b0);
               MainOutput:  ;
               MainFeature: emit_fields(u, 1'b1);
               MainColl: begin
                  if (m_nusage > 1) begin
                     raise_error(ST_COLL_USAGES);
                     return;
                  end
                  if (m_depth == 0 && u != CollApplication) begin
                     raise_error(ST_NOT_APP);
                     return;
                  end
                  if (m_depth >= NestDepth) begin
                     raise_error(ST_NESTING);
                     return;
                  end
                  m_colls[m_depth] = (m_nusage > 0) ? m_usages[0] : '0;
                  m_depth++;
               end
               MainEndColl: begin
                  if (m_depth == 0) begin
                     raise_error(ST_UNMATCHED);
                     return;
                  end
                  m_depth--;
               end
               default: begin
                  raise_error(ST_MAIN_TAG);
                  return;
               end
            endcase
            m_nusage = 0;
         end
         TypeGlobal: begin
            case (itag)
               GlUsagePage: m_page = u[15:0];
               GlLogMin:    m_lmin = s;
               GlLogMax:    m_lmax = s;
               4'h3, 4'h4, 4'h5, 4'h6: ;
               GlRepSize: begin
                  if (u > 32) raise_error(ST_SIZE);
                  else m_rsize = u[5:0];
               end
               GlRepId:     m_rid = u;
               GlRepCount:  m_rcount = u;
               4'ha, 4'hb:  raise_error(ST_PUSH_POP);
               default:     raise_error(ST_GLOBAL_TAG);
            endcase
         end
         TypeLocal: begin
            case (itag)
               LcUsage: begin
                  if (m_nusage >= UsageDepth) raise_error(ST_USAGES_FULL);
                  else if (u == 0) raise_error(ST_ZERO_USAGE);
                  else begin
                     m_usages[m_nusage] = (u < 32'h10000) ? {m_page, u[15:0]} : u;
                     m_nusage++;
                  end
               end
               LcUsageMin: ;
               LcUsageMax: raise_error(ST_USAGE_RANGE);
               4'h3, 4'h4, 4'h5, 4'h7, 4'h8, 4'h9: ;
               LcDelim: raise_error(ST_DELIMITER);
               default: raise_error(ST_LOCAL_TAG);
            endcase
         end
         default: raise_error(ST_LONG_ITEM);
      endcase
   endfunction

   // one accepted descriptor byte
   function automatic void model_byte(logic [7:0] b, logic last);
      int pos;
      if (!m_stuck) begin
         if (m_pending == 0) begin
            m_prefix = b;
            m_value = '0;
            m_pending = size_of(b);
         end else begin
            pos = (size_of(m_prefix) - m_pending) & 3;
            m_value = m_value | (32'(b) << (8 * pos));
            m_pending--;
         end
         if (m_pending == 0) finish_item();
         else if (last) raise_error(ST_OVERFLOW);
      end
      if (last) model_clear();
   endfunction

   // ---------------------------------------------------------------------
   // descriptor construction
   // ---------------------------------------------------------------------
   task automatic add_item(logic [1:0] ity, logic [3:0] itag, logic [1:0] sc,
                           logic [31:0] v);
      int n;
      n = (sc == 2'd3) ? 4 : int'(sc);
      build_bytes.push_back({itag, ity, sc});
      for (int i = 0; i < n; i++) build_bytes.push_back(v[8*i +: 8]);
   endtask

   // moves the built descriptor to the send queue, tlast on its final byte
   task automatic commit_descriptor();
      desc_byte_type d;
      while (build_bytes.size() > 0) begin
         d.data = build_bytes.pop_front();
         d.last = (build_bytes.size() == 0);
         byte_queue.push_back(d);
      end
   endtask

   function automatic logic [1:0] rand_sc();
      return 2'($urandom_range(0, 3));
   endfunction

   task automatic add_rand_value(logic [1:0] ity, logic [3:0] itag);
      add_item(ity, itag, rand_sc(), $urandom);
   endtask

   task automatic add_globals();
      if ($urandom_range(0, 3) == 0) add_item(TypeGlobal, GlUsagePage, 2'd2, $urandom);
      if ($urandom_range(0, 2) == 0) add_rand_value(TypeGlobal, GlLogMin);
      if ($urandom_range(0, 2) == 0) add_rand_value(TypeGlobal, GlLogMax);
      if ($urandom_range(0, 2) == 0)
         add_item(TypeGlobal, GlRepSize, 2'd1,
                  ($urandom_range(0, 19) == 0) ? $urandom_range(33, 255)
                                               : $urandom_range(0, 32));
      if ($urandom_range(0, 3) == 0)
         case ($urandom_range(0, 19))
            0:       add_item(TypeGlobal, GlRepId, rand_sc(), 0);
            1:       add_item(TypeGlobal, GlRepId, 2'd2, $urandom_range(256, 65535));
            default: add_item(TypeGlobal, GlRepId, 2'd1, $urandom_range(1, 255));
         endcase
      if ($urandom_range(0, 2) == 0)
         add_item(TypeGlobal, GlRepCount, 2'd1,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(9, 80)
                                              : $urandom_range(0, 8));
      if ($urandom_range(0, 9) == 0) add_rand_value(TypeGlobal, GlPhysMin);
   endtask

   task automatic add_usages(int n);
      for (int i = 0; i < n; i++)
         if ($urandom_range(0, 3) == 0) add_item(TypeLocal, LcUsage, 2'd3, $urandom);
         else add_item(TypeLocal, LcUsage, 2'($urandom_range(1, 2)),
                       $urandom_range(1, 65535));
      if ($urandom_range(0, 9) == 0) add_rand_value(TypeLocal, LcDesig);
      if ($urandom_range(0, 9) == 0) add_rand_value(TypeLocal, LcUsageMin);
   endtask

   // mostly well formed: application collection holding random fields
   task automatic random_descriptor();
      int nfields, open;
      open = 1;
      add_item(TypeGlobal, GlUsagePage, 2'd1, $urandom_range(1, 255));
      add_item(TypeGlobal, GlRepId, 2'd1, $urandom_range(1, 255));
      add_usages($urandom_range(0, 1));
      add_item(TypeMain, MainColl, 2'd1, CollApplication);
      nfields = $urandom_range(1, 6);
      for (int f = 0; f < nfields; f++) begin
         add_globals();
         add_usages($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0: begin
               add_item(TypeMain, MainColl, 2'd1, $urandom_range(0, 255));
               open++;
            end
            1: if (open > 1) begin
               add_item(TypeMain, MainEndColl, 2'd0, 0);
               open--;
            end
            2:       add_rand_value(TypeMain, MainOutput);
            3:       add_rand_value(TypeMain, MainFeature);
            4:       build_bytes.push_back(8'($urandom));  // noise byte
            default: add_rand_value(TypeMain, MainInput);
         endcase
      end
      repeat (open) add_item(TypeMain, MainEndColl, 2'd0, 0);
      // occasionally cut the last item short
      if ($urandom_range(0, 9) == 0)
         build_bytes.push_back({4'($urandom), 2'($urandom), 2'($urandom_range(1, 3))});
      commit_descriptor();
   endtask

   // raw noise: random prefixes and data
   task automatic noise_descriptor();
      repeat ($urandom_range(1, 12)) build_bytes.push_back(8'($urandom));
      commit_descriptor();
   endtask

   task automatic directed_descriptors();
      // every error code, each in its own descriptor
      add_item(TypeMain, MainInput, 2'd1, 0);                   commit_descriptor();
      add_item(TypeGlobal, GlRepId, 2'd2, 256);
      add_item(TypeMain, MainInput, 2'd0, 0);                   commit_descriptor();
      add_item(TypeGlobal, GlRepId, 2'd1, 1);
      repeat (FieldsPerReport + 1) add_item(TypeMain, MainFeature, 2'd0, 0);
      commit_descriptor();
      add_item(TypeLocal, LcUsage, 2'd1, 1);
      add_item(TypeLocal, LcUsage, 2'd1, 2);
      add_item(TypeMain, MainColl, 2'd1, CollApplication);      commit_descriptor();
      add_item(TypeMain, MainColl, 2'd1, 2);                    commit_descriptor();
      add_item(TypeMain, MainColl, 2'd1, CollApplication);
      repeat (NestDepth) add_item(TypeMain, MainColl, 2'd0, 0); commit_descriptor();
      add_item(TypeMain, MainEndColl, 2'd0, 0);                 commit_descriptor();
      add_item(TypeMain, MainBadTag, 2'd0, 0);                  commit_descriptor();
      add_item(TypeGlobal, GlRepSize, 2'd1, 33);                commit_descriptor();
      add_item(TypeGlobal, GlPush, 2'd0, 0);                    commit_descriptor();
      add_item(TypeGlobal, GlReserved, 2'd0, 0);                commit_descriptor();
      repeat (UsageDepth + 1) add_item(TypeLocal, LcUsage, 2'd1, 1);
      commit_descriptor();
      add_item(TypeLocal, LcUsage, 2'd0, 0);                    commit_descriptor();
      add_item(TypeLocal, LcUsageMax, 2'd0, 0);                 commit_descriptor();
      add_item(TypeLocal, LcDelim, 2'd0, 0);                    commit_descriptor();
      add_item(TypeLocal, LcReserved, 2'd0, 0);                 commit_descriptor();
      add_item(TypeLong, 4'hf, 2'd3, 32'hffffffff);             commit_descriptor();
      build_bytes.push_back({MainInput, TypeMain, 2'd1});       commit_descriptor();
      // extremes: id 255, full width values, count beyond the usage list,
      // a field with no usages, 4-byte usage, ignored items
      add_item(TypeGlobal, GlUsagePage, 2'd2, 16'hffff);
      add_item(TypeGlobal, GlRepId, 2'd1, 255);
      add_item(TypeGlobal, GlLogMin, 2'd3, 32'h80000000);
      add_item(TypeGlobal, GlLogMax, 2'd3, 32'h7fffffff);
      add_item(TypeGlobal, GlRepSize, 2'd1, 32);
      add_item(TypeGlobal, GlRepCount, 2'd3, 32'hffffffff);
      add_item(TypeLocal, LcUsage, 2'd3, 32'hfffe0001);
      add_item(TypeMain, MainColl, 2'd1, CollApplication);
      add_item(TypeLocal, LcUsage, 2'd1, 8'hff);
      add_item(TypeMain, MainInput, 2'd1, 8'h06);
      add_item(TypeGlobal, GlLogMin, 2'd1, 8'h80);
      add_item(TypeGlobal, GlLogMax, 2'd2, 16'h8000);
      add_item(TypeGlobal, GlRepCount, 2'd1, 0);
      add_item(TypeMain, MainOutput, 2'd0, 0);
      add_item(TypeMain, MainFeature, 2'd0, 0);
      add_item(TypeMain, MainEndColl, 2'd0, 0);
      commit_descriptor();
   endtask

   // ---------------------------------------------------------------------
   // clock, reset, stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int bytes_made;
      reset = 1'b1;
      model_clear();
      directed_descriptors();
      bytes_made = 0;
      while (bytes_made < 420) begin
         if ($urandom_range(0, 4) == 0) noise_descriptor();
         else random_descriptor();
         bytes_made = bytes_made + byte_queue.size() - bytes_made;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (byte_queue.size() == 0 && !req_tvalid && expected_words.size() == 0);
      repeat (600) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // driver: bursts of bytes with random gaps, model updated on acceptance
   // ---------------------------------------------------------------------
   int burst_left = 0, gap_left = 0;

   always @(posedge clock) begin
      desc_byte_type d;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) model_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               d = byte_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= d.data;
               req_tlast  <= d.last;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: own stall pattern plus one long hold-off, then compare
   // ---------------------------------------------------------------------
   int  stall_left = 0, run_left = 0;
   bit  held_off = 0;

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '0;
            got.status            = rsp_tdata[4:0];
            got.is_feature        = rsp_tdata[5];
            got.report_number     = rsp_tdata[13:6];
            got.field_slot        = rsp_tdata[17:14];
            got.root_usage        = rsp_tdata[49:18];
            got.usage_code        = rsp_tdata[81:50];
            got.logical_low       = rsp_tdata[113:82];
            got.logical_high      = rsp_tdata[145:114];
            got.bits_per_control  = rsp_tdata[151:146];
            got.control_count     = rsp_tdata[183:152];
            got.field_flags       = rsp_tdata[185:184];
            got.last_of_run       = rsp_tlast;
            if (expected_words.size() == 0) begin
               report("unexpected word", 32'(got.status), '0);
            end else begin
               want = expected_words.pop_front();
               if (got.status != want.status)
                  report("status", 32'(got.status), 32'(want.status));
               if (got.is_feature != want.is_feature)
                  report("is_feature", 32'(got.is_feature), 32'(want.is_feature));
               if (got.report_number != want.report_number)
                  report("report_number", 32'(got.report_number), 32'(want.report_number));
               if (got.field_slot != want.field_slot)
                  report("field_slot", 32'(got.field_slot), 32'(want.field_slot));
               if (got.root_usage != want.root_usage)
                  report("root usage", got.root_usage, want.root_usage);
               if (got.usage_code != want.usage_code)
                  report("usage_code", got.usage_code, want.usage_code);
               if (got.logical_low != want.logical_low)
                  report("logical_low", got.logical_low, want.logical_low);
               if (got.logical_high != want.logical_high)
                  report("logical_high", got.logical_high, want.logical_high);
               if (got.bits_per_control != want.bits_per_control)
                  report("bits_per_control", 32'(got.bits_per_control),
                         32'(want.bits_per_control));
               if (got.control_count != want.control_count)
                  report("control_count", got.control_count, want.control_count);
               if (got.field_flags != want.field_flags)
                  report("field_flags", 32'(got.field_flags), 32'(want.field_flags));
               if (got.last_of_run != want.last_of_run)
                  report("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
               if (rsp_tdata[191:186] != '0)
                  report("zero fill", 32'(rsp_tdata[191:186]), '0);
            end
         end
         // one long hold-off once a big run is pending so the input backs up
         if (!held_off && expected_words.size() >= 8) begin
            held_off = 1;
            stall_left = HoldOff;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 8);
            rsp_tready <= 1'b0;
         end else begin
            run_left = $urandom_range(0, 30);
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: cycles without any handshake
   // ---------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end
endmodule
`default_nettype wire
